FILE: src/pidc_pkg.sv
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned LimW  = 31;
  localparam int unsigned DtFrac = 24;

  typedef enum logic [2:0] {
    CfgKp    = 3'd0,
    CfgKi    = 3'd1,
    CfgKd    = 3'd2,
    CfgTgt   = 3'd3,
    CfgUpper = 3'd4,
    CfgLower = 3'd5,
    CfgLimit = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StMulInc,
    StInteg,
    StMulP,
    StMulI,
    StMulD,
    StDivLoad,
    StDiv,
    StSum,
    StOut
  } state_e;

  // Control from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;
    logic a_neg;
  } mul_ctl_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      if (v > mx) sat32 = 32'sh7fffffff;
      else if (v < mn) sat32 = 32'sh80000000;
      else sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

FILE: src/pidc_if.sv
interface pidc_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  measured_angle;
  logic        [31:0]  time_step;
  modport source (output valid, measured_angle, time_step, input ready);
  modport sink   (input valid, measured_angle, time_step, output ready);
endinterface

interface pidc_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  drive_value;
  logic                output_clamped;
  logic                integral_clamped;
  modport source (output valid, drive_value, output_clamped, integral_clamped,
                  input ready);
  modport sink   (input valid, drive_value, output_clamped, integral_clamped,
                  output ready);
endinterface

FILE: src/pidc_mul.sv
// Shift-and-add multiplier: one bit of the 33-bit multiplier magnitude per cycle.
module pidc_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidc_pkg::mul_ctl_t  ctl_i,
  input  logic signed [33:0]  a_i,
  input  logic        [32:0]  b_i,
  output logic                done_o,
  output logic signed [66:0]  p_o
);
  import pidc_pkg::*;

  logic [66:0] acc_q, acc_d;
  logic [66:0] acc_nx;
  logic [32:0] b_q, b_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;

  // The product is taken from the last step itself, so a new start in the
  // done cycle does not disturb it.
  always_comb begin
    acc_nx = {acc_q[65:0], 1'b0};
    if (b_q[32]) acc_nx = {acc_q[65:0], 1'b0} + {{33{a_i[33]}}, a_i};
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    if (ctl_i.start) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
      neg_d  = ctl_i.a_neg;
    end else if (busy_q) begin
      acc_d = acc_nx;
      b_d   = {b_q[31:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd32);
  assign p_o    = neg_q ? -$signed(acc_nx) : $signed(acc_nx);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ctl_i.start) |=> !busy_q) else $error("multiplier busy after done");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q) else $error("multiplier did not start");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'd33) else $error("multiplier count overrun");
endmodule

FILE: src/pid_controller_clamped_core.sv
// PID step with integral clamp, signed fixed point with FRAC_BITS fraction
// bits; time step is unsigned Q8.24 seconds.
// Input channel (in_if): a word with measured_angle and time_step. Output
// channel (out_if): one word per input with drive_value, output_clamped and
// integral_clamped. Both use valid/ready; a word moves when both are high.
// Configuration: write cfg_we_i with cfg_idx_i (0 kp, 1 ki, 2 kd, 3 target,
// 4 upper, 5 lower, 6 integral limit) and cfg_data_i, only while idle.
// One word is processed at a time. A shared bit-serial multiplier runs four
// times (increment, P, I, D numerator); the restoring divider for the
// derivative then shifts one quotient bit a cycle over 66 + 24 - FRAC_BITS
// steps. The next word can be taken in the cycle after the result leaves.
// Reset restores the default gains and limits and clears the integral and
// the previous error. A stalled receiver holds the result in the output
// register; no new input is taken until the result is taken.
module pid_controller_clamped_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidc_in_if.sink     in_if,
  pidc_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import pidc_pkg::*;

  localparam int unsigned DShift = DtFrac - FRAC_BITS;
  localparam int unsigned NumW   = 66 + DShift;
  localparam int unsigned DivSteps = NumW;

  logic signed [31:0] kp_q, ki_q, kd_q, tgt_q, upper_q, lower_q;
  logic        [30:0] limit_q;
  logic signed [31:0] integ_q, integ_d, lerr_q, lerr_d;

  state_e state_q, state_d;

  logic signed [31:0] err_q, err_d;
  logic        [31:0] dt_q, dt_d;
  logic signed [31:0] p_q, p_d, i_q, i_d, d_q, d_d;
  logic signed [65:0] num_q, num_d;
  logic               iclamp_q, iclamp_d;
  logic signed [31:0] drive_q, drive_d;
  logic               oclamp_q, oclamp_d;
  logic               ovalid_q, ovalid_d;

  logic [NumW-1:0]    dnum_q, dnum_d;
  logic [32:0]        drem_q, drem_d;
  logic [6:0]         dcnt_q, dcnt_d;
  logic               dneg_q, dneg_d;
  logic [31:0]        quo_q, quo_d;
  logic               qsat_q, qsat_d;

  mul_ctl_t           mctl;
  logic signed [33:0] ma;
  logic        [32:0] mb;
  logic               mdone;
  logic signed [66:0] mp;

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mdone),
    .p_o    (mp)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= 32'sd3276800;
      ki_q    <= 32'sd327680;
      kd_q    <= 32'sd131072;
      tgt_q   <= '0;
      upper_q <= 32'sd327680000;
      lower_q <= -32'sd327680000;
      limit_q <= 31'd65536000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKp:    kp_q    <= cfg_data_i;
        CfgKi:    ki_q    <= cfg_data_i;
        CfgKd:    kd_q    <= cfg_data_i;
        CfgTgt:   tgt_q   <= cfg_data_i;
        CfgUpper: upper_q <= cfg_data_i;
        CfgLower: lower_q <= cfg_data_i;
        CfgLimit: limit_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_if.valid && !ovalid_q) state_d = StMulInc;
      StMulInc:  if (mdone) state_d = StInteg;
      StInteg:   state_d = StMulP;
      StMulP:    if (mdone) state_d = StMulI;
      StMulI:    if (mdone) state_d = StMulD;
      StMulD:    if (mdone) state_d = StDivLoad;
      StDivLoad: state_d = StDiv;
      StDiv:     if (dcnt_q == 7'(DivSteps - 1)) state_d = StSum;
      StSum:     state_d = StOut;
      StOut:     state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Multiplier operand selection; the signed operand is given as a
  // 34-bit value and the other as a 33-bit magnitude with its sign.
  logic signed [32:0] ediff;
  logic signed [32:0] bsrc;
  logic               bneg;
  always_comb begin
    ediff = 33'(err_q) - 33'(lerr_q);
    ma    = 34'(err_q);
    unique case (state_q)
      StMulP: ma = 34'(kp_q);
      StMulI: ma = 34'(ki_q);
      StMulD: ma = 34'(kd_q);
      default: ;
    endcase
    // The magnitude operand is latched on the start cycle, which is still
    // in the state before the product's own state.
    unique case (state_q)
      StIdle:  bsrc = {1'b0, in_if.time_step};
      StInteg: bsrc = 33'(err_q);
      StMulP:  bsrc = 33'(integ_q);
      StMulI:  bsrc = ediff;
      default: bsrc = {1'b0, dt_q};
    endcase
    bneg = bsrc[32];
    mb   = bneg ? 33'(-bsrc) : bsrc;
    mctl.a_neg = bneg;
    mctl.start = (state_q == StIdle && in_if.valid && !ovalid_q)
              || (state_q == StInteg)
              || (mdone && (state_q == StMulP || state_q == StMulI));
  end

  // Datapath.
  logic signed [65:0] ninteg;
  logic signed [65:0] lim_s;
  logic signed [33:0] sum;
  logic signed [32:0] tdiff;
  logic [32:0]        rsh;
  logic [31:0]        qn;
  always_comb begin
    err_d    = err_q;
    dt_d     = dt_q;
    integ_d  = integ_q;
    lerr_d   = lerr_q;
    p_d      = p_q;
    i_d      = i_q;
    d_d      = d_q;
    num_d    = num_q;
    iclamp_d = iclamp_q;
    drive_d  = drive_q;
    oclamp_d = oclamp_q;
    ovalid_d = ovalid_q;
    dnum_d   = dnum_q;
    drem_d   = drem_q;
    dcnt_d   = dcnt_q;
    dneg_d   = dneg_q;
    quo_d    = quo_q;
    qsat_d   = qsat_q;
    lim_s    = 66'(limit_q);
    ninteg   = 66'(integ_q) + (num_q >>> DtFrac);
    sum      = 34'(p_q) + 34'(i_q) + 34'(d_q);
    tdiff    = 33'(tgt_q) - 33'(in_if.measured_angle);
    rsh      = {drem_q[31:0], dnum_q[NumW-1]};
    qn       = quo_q;

    if (out_if.valid && out_if.ready) ovalid_d = 1'b0;

    unique case (state_q)
      StIdle: if (in_if.valid && !ovalid_q) begin
        err_d = sat32(66'(tdiff));
        dt_d  = in_if.time_step;
      end
      StMulInc: if (mdone) num_d = mp[65:0];
      StInteg: begin
        iclamp_d = 1'b0;
        if (ninteg > lim_s) begin
          integ_d = 32'(limit_q); iclamp_d = 1'b1;
        end else if (ninteg < -lim_s) begin
          integ_d = -32'(limit_q); iclamp_d = 1'b1;
        end else begin
          integ_d = ninteg[31:0];
        end
      end
      StMulP: if (mdone) p_d = sat32($signed(mp[65:0]) >>> FRAC_BITS);
      StMulI: if (mdone) i_d = sat32($signed(mp[65:0]) >>> FRAC_BITS);
      StMulD: if (mdone) num_d = mp[65:0];
      StDivLoad: begin
        dneg_d = num_q[65];
        dnum_d = NumW'(num_q[65] ? 66'(-num_q) : num_q) << DShift;
        drem_d = '0;
        dcnt_d = '0;
        quo_d  = '0;
        qsat_d = 1'b0;
      end
      StDiv: begin
        // Restoring step; the quotient saturates at 2^31.
        dnum_d = {dnum_q[NumW-2:0], 1'b0};
        if (rsh >= {1'b0, dt_q}) begin
          drem_d = rsh - {1'b0, dt_q};
          if (quo_q[31] || qsat_q) qsat_d = 1'b1;
          qn = {quo_q[30:0], 1'b1};
        end else begin
          drem_d = rsh;
          if (quo_q[31] || qsat_q) qsat_d = 1'b1;
          qn = {quo_q[30:0], 1'b0};
        end
        quo_d  = qn;
        dcnt_d = dcnt_q + 7'd1;
      end
      StSum: begin
        if (dt_q == '0) d_d = '0;
        else if (dneg_q) d_d = (qsat_q || quo_q[31]) ? 32'sh80000000 : -$signed(quo_q);
        else d_d = (qsat_q || quo_q[31]) ? 32'sh7fffffff : $signed(quo_q);
      end
      StOut: begin
        lerr_d   = err_q;
        ovalid_d = 1'b1;
        oclamp_d = 1'b1;
        if (sum > 34'(upper_q)) drive_d = upper_q;
        else if (sum < 34'(lower_q)) drive_d = lower_q;
        else begin drive_d = sum[31:0]; oclamp_d = 1'b0; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      integ_q  <= '0;
      lerr_q   <= '0;
      ovalid_q <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      integ_q  <= integ_d;
      lerr_q   <= lerr_d;
      ovalid_q <= ovalid_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    dt_q     <= dt_d;
    p_q      <= p_d;
    i_q      <= i_d;
    d_q      <= d_d;
    num_q    <= num_d;
    iclamp_q <= iclamp_d;
    drive_q  <= drive_d;
    oclamp_q <= oclamp_d;
    dnum_q   <= dnum_d;
    drem_q   <= drem_d;
    dneg_q   <= dneg_d;
    quo_q    <= quo_d;
    qsat_q   <= qsat_d;
  end

  assign in_if.ready             = (state_q == StIdle) && !ovalid_q;
  assign out_if.valid            = ovalid_q;
  assign out_if.drive_value      = drive_q;
  assign out_if.output_clamped   = oclamp_q;
  assign out_if.integral_clamped = iclamp_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second word taken while busy");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == StOut)
    else $error("result raised outside output step");
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMulP) |-> (integ_q <= $signed({1'b0, limit_q})
      && integ_q >= -$signed({1'b0, limit_q})))
    else $error("integral beyond limit");
endmodule
